FILE: design/circle_pair_contact_top_defines.svh
// Assertion macros shared by the circle pair contact design.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef CIRCLE_PAIR_CONTACT_TOP_DEFINES_SVH
`define CIRCLE_PAIR_CONTACT_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define CCP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only out of reset.
`define CCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ccp_pkg.sv
// Shared types and constants for the circle pair contact pipeline.
// No dependencies.
package ccp_pkg;

	localparam int SQ_STEPS  = 32;
	localparam int NORM_BITS = 14;
	localparam int Q_W       = NORM_BITS + 1;
	localparam int DIV_W     = 48;
	localparam int REM_W     = 36;

	localparam logic [Q_W-1:0]   NORM_ONE = Q_W'(1 << NORM_BITS);
	localparam logic signed [15:0] NORM_MAX = 16'sd16384;

	// Per-item context carried down the whole chain
	typedef struct packed {
		logic [15:0]        tag_a;
		logic [15:0]        tag_b;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [30:0]        ra;
		logic [30:0]        rb;
		logic [31:0]        rs;
		logic               hit;
		logic               sx;
		logic               sy;
		logic [31:0]        mx;
		logic [31:0]        my;
	} ctx_t;

	// Square root cell payload
	typedef struct packed {
		ctx_t             ctx;
		logic [63:0]      rad;
		logic [REM_W-1:0] rem;
		logic [31:0]      root;
	} sq_t;

	// Divider cell payload
	typedef struct packed {
		ctx_t             ctx;
		logic [31:0]      dlen;
		logic [DIV_W-1:0] rem_x;
		logic [DIV_W-1:0] rem_y;
		logic [Q_W-1:0]   q_x;
		logic [Q_W-1:0]   q_y;
	} dv_t;

	// Finished result
	typedef struct packed {
		logic               hit;
		logic [15:0]        tag_a;
		logic [15:0]        tag_b;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic [31:0]        depth;
	} res_t;

endpackage

FILE: design/ccp_front.sv
// Front stages: offsets, squares and the contact compare.
// Depends on ccp_pkg.
module ccp_front import ccp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [15:0]        first_tag,
	input  logic [15:0]        second_tag,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic [30:0]        first_radius,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic [30:0]        second_radius,
	output logic               v_o,
	output sq_t                o
);

	logic v_s1, v_s2, v_s3;
	ctx_t c_s1, c_s2, c_s3;
	logic [63:0] sqx_s2, sqy_s2, rs2_s2;
	logic [63:0] d2_s3;

	ctx_t c_in;
	ctx_t c_cmp;
	logic [64:0] d2_sum;

	// Build context with absolute offsets and radius sum
	always_comb begin
		c_in.tag_a = first_tag;
		c_in.tag_b = second_tag;
		c_in.ax = first_x;
		c_in.ay = first_y;
		c_in.bx = second_x;
		c_in.by = second_y;
		c_in.ra = first_radius;
		c_in.rb = second_radius;
		c_in.rs = {1'b0, first_radius} + {1'b0, second_radius};
		c_in.hit = 1'b0;
		c_in.sx = second_x < first_x;
		c_in.sy = second_y < first_y;
		c_in.mx = c_in.sx ? 32'(first_x - second_x) : 32'(second_x - first_x);
		c_in.my = c_in.sy ? 32'(first_y - second_y) : 32'(second_y - first_y);
	end

	assign d2_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	// Mark contact when the squared distance fits and is within reach
	always_comb begin
		c_cmp = c_s2;
		c_cmp.hit = !d2_sum[64] && (d2_sum[63:0] <= rs2_s2);
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Advance payload: capture, square, compare
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= c_in;
			c_s2 <= c_s1;
			sqx_s2 <= c_s1.mx * c_s1.mx;
			sqy_s2 <= c_s1.my * c_s1.my;
			rs2_s2 <= c_s1.rs * c_s1.rs;
			c_s3 <= c_cmp;
			d2_s3 <= d2_sum[63:0];
		end
	end

	assign v_o = v_s3;

	always_comb begin
		o.ctx = c_s3;
		o.rad = d2_s3;
		o.rem = '0;
		o.root = '0;
	end

endmodule

FILE: design/ccp_sqrt_cell.sv
// One root bit of the digit-by-digit square root.
// Depends on ccp_pkg.
module ccp_sqrt_cell import ccp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_i,
	input  sq_t  i,
	output logic v_o,
	output sq_t  o
);

	logic v_q;
	sq_t  d_q;
	sq_t  nxt;
	logic [REM_W-1:0] r2;
	logic [REM_W-1:0] trial;
	logic ge;

	// Bring down two radicand bits and try the next root bit
	always_comb begin
		r2 = {i.rem[REM_W-3:0], i.rad[63:62]};
		trial = {{(REM_W-34){1'b0}}, i.root, 2'b01};
		ge = r2 >= trial;
		nxt.ctx = i.ctx;
		nxt.rad = {i.rad[61:0], 2'b00};
		nxt.rem = ge ? (r2 - trial) : r2;
		nxt.root = {i.root[30:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign v_o = v_q;
	assign o = d_q;

endmodule

FILE: design/ccp_div_cell.sv
// One quotient bit of both normal components, restoring division.
// Depends on ccp_pkg.
module ccp_div_cell import ccp_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_i,
	input  dv_t  i,
	output logic v_o,
	output dv_t  o
);

	logic v_q;
	dv_t  d_q;
	dv_t  nxt;
	logic [DIV_W-1:0] d_sh;
	logic ge_x, ge_y;

	// Subtract the shifted divisor where it fits
	always_comb begin
		d_sh = DIV_W'({i.dlen, 1'b0}) << BIT;
		ge_x = i.rem_x >= d_sh;
		ge_y = i.rem_y >= d_sh;
		nxt = i;
		nxt.rem_x = ge_x ? (i.rem_x - d_sh) : i.rem_x;
		nxt.rem_y = ge_y ? (i.rem_y - d_sh) : i.rem_y;
		nxt.q_x[BIT] = ge_x;
		nxt.q_y[BIT] = ge_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign v_o = v_q;
	assign o = d_q;

endmodule

FILE: design/ccp_back.sv
// Back stages: scale the normal by the radii, place rim points, saturate.
// Depends on ccp_pkg.
module ccp_back import ccp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_i,
	input  dv_t  i,
	output logic v_o,
	output res_t o
);

	logic v_s1, v_s2;
	ctx_t c_s1;
	logic [Q_W-1:0] qx_s1, qy_s1;
	logic [45:0] pxa_s1, pya_s1, pxb_s1, pyb_s1;
	logic [31:0] depth_s1;
	res_t r_s2;

	logic [Q_W-1:0] nqx, nqy;
	res_t r_nxt;

	function automatic logic [32:0] rnd(input logic [45:0] p);
		logic [46:0] t;
		t = {1'b0, p} + 47'(1 << (NORM_BITS - 1));
		return t[46:NORM_BITS];
	endfunction

	function automatic logic [31:0] move_sat(input logic signed [31:0] base,
			input logic [32:0] q, input logic neg);
		logic [34:0] b35, q35, s;
		b35 = {{3{base[31]}}, base};
		q35 = {2'b00, q};
		s = neg ? (b35 - q35) : (b35 + q35);
		if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) begin
			return s[31:0];
		end
		return s[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	// Clamp the quotients; coincident centers give a zero normal
	always_comb begin
		nqx = (i.dlen == '0) ? '0 : ((i.q_x > NORM_ONE) ? NORM_ONE : i.q_x);
		nqy = (i.dlen == '0) ? '0 : ((i.q_y > NORM_ONE) ? NORM_ONE : i.q_y);
	end

	// Assemble the result, zero on a miss
	always_comb begin
		r_nxt = '0;
		if (c_s1.hit) begin
			r_nxt.hit = 1'b1;
			r_nxt.tag_a = c_s1.tag_a;
			r_nxt.tag_b = c_s1.tag_b;
			r_nxt.nx = c_s1.sx ? -$signed({1'b0, qx_s1}) : $signed({1'b0, qx_s1});
			r_nxt.ny = c_s1.sy ? -$signed({1'b0, qy_s1}) : $signed({1'b0, qy_s1});
			r_nxt.sx = move_sat(c_s1.bx, rnd(pxb_s1), !c_s1.sx);
			r_nxt.sy = move_sat(c_s1.by, rnd(pyb_s1), !c_s1.sy);
			r_nxt.ex = move_sat(c_s1.ax, rnd(pxa_s1), c_s1.sx);
			r_nxt.ey = move_sat(c_s1.ay, rnd(pya_s1), c_s1.sy);
			r_nxt.depth = depth_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
		end
	end

	// Advance payload: products, then rounding and placement
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= i.ctx;
			qx_s1 <= nqx;
			qy_s1 <= nqy;
			pxa_s1 <= 46'(nqx) * 46'(i.ctx.ra);
			pya_s1 <= 46'(nqy) * 46'(i.ctx.ra);
			pxb_s1 <= 46'(nqx) * 46'(i.ctx.rb);
			pyb_s1 <= 46'(nqy) * 46'(i.ctx.rb);
			depth_s1 <= i.ctx.rs - i.dlen;
			r_s2 <= r_nxt;
		end
	end

	assign v_o = v_s2;
	assign o = r_s2;

endmodule

FILE: design/circle_pair_contact_top.sv
// Circle pair contact test: one pair of circles in, one contact result out.
// From input transfer to out_valid: 3 front stages, 32 square root cells,
// 1 divider setup stage, 15 divider cells, 2 back stages. Throughput one
// item per cycle while in_stall is low; an output skid register absorbs one result.
// Reset clears all valids and the skid; payload registers are not reset.
module circle_pair_contact_top import ccp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        first_tag,
	input  logic [15:0]        second_tag,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic [30:0]        first_radius,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic [30:0]        second_radius,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [15:0]        tag_a_out,
	output logic [15:0]        tag_b_out,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [31:0] start_x,
	output logic signed [31:0] start_y,
	output logic signed [31:0] end_x,
	output logic signed [31:0] end_y,
	output logic [31:0]        depth
);

`include "circle_pair_contact_top_defines.svh"

	logic pipe_en;
	logic sq_v [0:SQ_STEPS];
	sq_t  sq   [0:SQ_STEPS];
	logic dv_v [0:Q_W];
	dv_t  dv   [0:Q_W];
	logic prep_v_q;
	dv_t  prep_q;
	dv_t  prep_nxt;
	logic pv;
	res_t p;
	logic skid_v_q;
	res_t skid_q;
	res_t r;

	assign pipe_en = !skid_v_q;
	assign in_stall = skid_v_q;

	ccp_front u_front (
		.clk, .arst_n, .en(pipe_en), .in_valid,
		.first_tag, .second_tag, .first_x, .first_y, .first_radius,
		.second_x, .second_y, .second_radius,
		.v_o(sq_v[0]), .o(sq[0])
	);

	// Square root chain, one root bit per cell
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		ccp_sqrt_cell u_cell (
			.clk, .arst_n, .en(pipe_en),
			.v_i(sq_v[k]), .i(sq[k]), .v_o(sq_v[k+1]), .o(sq[k+1])
		);
	end

	// Set up the rounded division: (mag * 2^15 + dlen) / (2 * dlen)
	always_comb begin
		prep_nxt.ctx = sq[SQ_STEPS].ctx;
		prep_nxt.dlen = sq[SQ_STEPS].root;
		prep_nxt.rem_x = {1'b0, sq[SQ_STEPS].ctx.mx, 15'b0} + {16'b0, sq[SQ_STEPS].root};
		prep_nxt.rem_y = {1'b0, sq[SQ_STEPS].ctx.my, 15'b0} + {16'b0, sq[SQ_STEPS].root};
		prep_nxt.q_x = '0;
		prep_nxt.q_y = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_v_q <= 1'b0;
		end else if (pipe_en) begin
			prep_v_q <= sq_v[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			prep_q <= prep_nxt;
		end
	end

	assign dv_v[0] = prep_v_q;
	assign dv[0] = prep_q;

	// Divider chain, most significant quotient bit first
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		ccp_div_cell #(.BIT(Q_W - 1 - k)) u_cell (
			.clk, .arst_n, .en(pipe_en),
			.v_i(dv_v[k]), .i(dv[k]), .v_o(dv_v[k+1]), .o(dv[k+1])
		);
	end

	ccp_back u_back (
		.clk, .arst_n, .en(pipe_en),
		.v_i(dv_v[Q_W]), .i(dv[Q_W]), .v_o(pv), .o(p)
	);

	// Skid: catch the result that a stalled transfer would lose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_stall) begin
				skid_v_q <= 1'b0;
			end
		end else if (pv && out_stall) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= p;
		end
	end

	assign out_valid = skid_v_q || pv;
	assign r = skid_v_q ? skid_q : p;

	assign hit = r.hit;
	assign tag_a_out = r.tag_a;
	assign tag_b_out = r.tag_b;
	assign normal_x = r.nx;
	assign normal_y = r.ny;
	assign start_x = r.sx;
	assign start_y = r.sy;
	assign end_x = r.ex;
	assign end_y = r.ey;
	assign depth = r.depth;

	`CCP_ASSERT_NEXT(a_skid_hold, skid_v_q && out_stall, skid_v_q && $stable(skid_q), "skid lost a stalled result")
	`CCP_ASSERT_NOW(a_skid_fill, $rose(skid_v_q), $past(pv && out_stall), "skid filled without a stalled result")
	`CCP_ASSERT_NOW(a_miss_zero, out_valid && !hit, normal_x == '0 && depth == '0 && tag_a_out == '0, "miss result not cleared")
	`CCP_ASSERT_NOW(a_norm_range, out_valid && hit, normal_x <= NORM_MAX && normal_x >= -NORM_MAX, "normal out of unit range")

endmodule
